// File: hdl/grs_pkg.sv
// Shared types, codes and defaults for the graph reachability search block.
// No dependencies; every other file in hdl/ uses it by scoped names.
package grs_pkg;

  // Default sizes, used as the defaults of the top-level parameters
  localparam int NODE_COUNT_DEF = 256;
  localparam int MAX_DEGREE_DEF = 16;

  // Operation codes
  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Search modes
  localparam logic MODE_DFS = 1'b0;
  localparam logic MODE_BFS = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_FOUND   = 2'd2;
  localparam logic [1:0] ST_UNREACH = 2'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] from_node;
    logic [7:0] to_node;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] explored_count;
  } out_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE,
    S_CLR,
    S_POP,
    S_NODE,
    S_CHK,
    S_DEG,
    S_NBR,
    S_PUSH,
    S_DONE
  } state_t;

  // Requests to the edge store
  typedef struct packed {
    logic       deg_rd;
    logic       deg_wr;
    logic       nb_rd;
    logic       nb_wr;
    logic [7:0] node;
    logic [7:0] slot;
    logic [8:0] deg_wdata;
    logic [7:0] nb_wdata;
  } gs_cmd_t;

  // Requests to the frontier
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } fr_cmd_t;

  // Node number inside the configured node range
  function automatic logic node_ok(input logic [7:0] n, input logic [16:0] nc);
    return {9'd0, n} < nc;
  endfunction

endpackage

// File: hdl/graph_reachability_search.sv
// Graph reachability search: an edge insert reads the degree on acceptance,
// writes the list slot and degree in S_EDGE when it is added and offers its
// result in S_DONE; the next transaction is taken in S_IDLE after the result is
// taken. A search first clears the visited map, one node per cycle (NODE_COUNT
// nodes, capped at 256), then for each frontier pop goes through pop, frontier
// read and visited check, a degree lookup for each newly visited node that is
// not the goal, and for each neighbor slot a list read, then a visited check and
// push, plus a final empty check when the goal is unreachable. A search with an
// out-of-range start answers at once. All of it is paced by the registered
// memory reads. One transaction is in flight at a time and the input stays
// stalled while a result waits; search_mode is taken on the cfg port and must be
// written idle.
// Depends on grs_pkg, grs_graph_store, grs_frontier, grs_seq.
module graph_reachability_search #(
  parameter int NODE_COUNT = grs_pkg::NODE_COUNT_DEF,
  parameter int MAX_DEGREE = grs_pkg::MAX_DEGREE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  grs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output grs_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_search_mode
);

  localparam int NU = (NODE_COUNT < 256) ? NODE_COUNT : 256;
  localparam int FD = NU * MAX_DEGREE + 1;

  logic             mode_r;
  grs_pkg::gs_cmd_t gs_cmd;
  grs_pkg::fr_cmd_t fr_cmd;
  logic [8:0]       deg_rdata;
  logic [7:0]       nb_rdata;
  logic [7:0]       fr_push_data;
  logic             fr_empty;
  logic [7:0]       fr_pop_data;

  // Mode register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= grs_pkg::MODE_DFS;
    end else if (cfg_valid) begin
      mode_r <= cfg_search_mode;
    end
  end

  grs_seq #(.NODE_COUNT(NODE_COUNT), .MAX_DEGREE(MAX_DEGREE)) u_seq (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .gs_cmd, .deg_rdata, .nb_rdata,
    .fr_cmd, .fr_push_data, .fr_empty, .fr_pop_data
  );

  grs_graph_store #(.NODE_COUNT(NODE_COUNT), .MAX_DEGREE(MAX_DEGREE)) u_store (
    .clk, .rst_n, .cmd(gs_cmd), .deg_rdata, .nb_rdata
  );

  grs_frontier #(.DEPTH(FD)) u_frontier (
    .clk, .rst_n, .cmd(fr_cmd), .mode(mode_r),
    .push_data(fr_push_data), .empty(fr_empty), .pop_data(fr_pop_data)
  );

endmodule

// File: hdl/grs_graph_store.sv
// Edge storage: per-node neighbor lists and degree counters.
// Depends on grs_pkg.
module grs_graph_store #(
  parameter int NODE_COUNT = grs_pkg::NODE_COUNT_DEF,
  parameter int MAX_DEGREE = grs_pkg::MAX_DEGREE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  grs_pkg::gs_cmd_t  cmd,
  output logic [8:0]        deg_rdata,
  output logic [7:0]        nb_rdata
);

  localparam int NU  = (NODE_COUNT < 256) ? NODE_COUNT : 256;
  localparam int NIW = (NU > 1) ? $clog2(NU) : 1;
  localparam int SIW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int DW  = $clog2(MAX_DEGREE + 1);
  localparam int NBD = NU * (1 << SIW);

  logic [DW-1:0] deg_mem [NU];
  logic [7:0]    nb_mem  [NBD];
  logic [NU-1:0] deg_valid_r;
  logic [DW-1:0] deg_q_r;
  logic          deg_vq_r;
  logic [7:0]    nb_q_r;

  logic [NIW-1:0] node_idx;
  logic [NIW+SIW-1:0] nb_addr;

  assign node_idx = cmd.node[NIW-1:0];
  assign nb_addr  = {node_idx, cmd.slot[SIW-1:0]};

  // Degree valid bits: an unwritten node reads as degree zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_valid_r <= '0;
    end else if (cmd.deg_wr) begin
      deg_valid_r[node_idx] <= 1'b1;
    end
  end

  // Degree memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.deg_wr) begin
      deg_mem[node_idx] <= cmd.deg_wdata[DW-1:0];
    end
    if (cmd.deg_rd) begin
      deg_q_r  <= deg_mem[node_idx];
      deg_vq_r <= deg_valid_r[node_idx];
    end
  end

  // Neighbor list memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.nb_wr) begin
      nb_mem[nb_addr] <= cmd.nb_wdata;
    end
    if (cmd.nb_rd) begin
      nb_q_r <= nb_mem[nb_addr];
    end
  end

  assign deg_rdata = deg_vq_r ? 9'(deg_q_r) : 9'd0;
  assign nb_rdata  = nb_q_r;

endmodule

// File: hdl/grs_frontier.sv
// Search frontier: one memory used as a stack (DFS) or a queue (BFS).
// Depends on grs_pkg.
module grs_frontier #(
  parameter int DEPTH = grs_pkg::NODE_COUNT_DEF * grs_pkg::MAX_DEGREE_DEF + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  grs_pkg::fr_cmd_t  cmd,
  input  logic              mode,
  input  logic [7:0]        push_data,
  output logic              empty,
  output logic [7:0]        pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = $clog2(DEPTH + 1);

  logic [7:0]    mem [DEPTH];
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] tail_m1;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    pop_r;

  assign tail_m1 = tail_r - PW'(1);

  // Pointer update; clear may come with the first push
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    wr_addr  = tail_r[AW-1:0];
    rd_addr  = (mode == grs_pkg::MODE_BFS) ? head_r[AW-1:0] : tail_m1[AW-1:0];
    if (cmd.clear) begin
      head_nxt = '0;
      tail_nxt = cmd.push ? PW'(1) : '0;
      wr_addr  = '0;
    end else begin
      if (cmd.push) begin
        tail_nxt = tail_r + PW'(1);
      end
      if (cmd.pop) begin
        if (mode == grs_pkg::MODE_BFS) begin
          head_nxt = head_r + PW'(1);
        end else begin
          tail_nxt = tail_m1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // Frontier memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= push_data;
    end
    if (cmd.pop) begin
      pop_r <= mem[rd_addr];
    end
  end

  assign empty    = (head_r == tail_r);
  assign pop_data = pop_r;

  // Never pop an empty frontier
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !empty) else $error("frontier pop while empty");

  // Never push past capacity
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && !cmd.clear) |-> (tail_r < PW'(DEPTH)))
    else $error("frontier overflow");

  // Head never passes tail
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r) else $error("frontier head passed tail");

endmodule

// File: hdl/grs_seq.sv
// Sequencer: edge insertion and the node-by-node search walk, visited map.
// Depends on grs_pkg; drives grs_graph_store and grs_frontier.
module grs_seq #(
  parameter int NODE_COUNT = grs_pkg::NODE_COUNT_DEF,
  parameter int MAX_DEGREE = grs_pkg::MAX_DEGREE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  grs_pkg::in_t      in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output grs_pkg::out_t     out_data,
  output grs_pkg::gs_cmd_t  gs_cmd,
  input  logic [8:0]        deg_rdata,
  input  logic [7:0]        nb_rdata,
  output grs_pkg::fr_cmd_t  fr_cmd,
  output logic [7:0]        fr_push_data,
  input  logic              fr_empty,
  input  logic [7:0]        fr_pop_data
);

  localparam int NU  = (NODE_COUNT < 256) ? NODE_COUNT : 256;
  localparam int NIW = (NU > 1) ? $clog2(NU) : 1;
  localparam logic [16:0] NC = 17'(NODE_COUNT);
  localparam logic [8:0]  MD = 9'(MAX_DEGREE);

  grs_pkg::state_t state_r, state_nxt;
  logic [7:0]    cur_r, cur_nxt;
  logic [7:0]    goal_r, goal_nxt;
  logic [8:0]    deg_r, deg_nxt;
  logic [8:0]    slot_r, slot_nxt;
  logic [8:0]    count_r, count_nxt;
  logic [7:0]    nb_r, nb_nxt;
  grs_pkg::out_t out_r, out_nxt;

  logic       in_acc;
  logic [8:0] slot_inc;
  logic       clr_last;

  // Visited map: one bit per node, registered read
  logic           vis_mem [NU];
  logic           vis_q_r;
  logic           vis_we;
  logic           vis_re;
  logic           vis_wdata;
  logic [NIW-1:0] vis_waddr;
  logic [NIW-1:0] vis_raddr;

  assign in_acc   = in_valid && in_ready;
  assign slot_inc = slot_r + 9'd1;
  assign clr_last = (slot_r == 9'(NU - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      grs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data.op == grs_pkg::OP_EDGE) begin
            state_nxt = grs_pkg::S_EDGE;
          end else if (grs_pkg::node_ok(in_data.from_node, NC)) begin
            state_nxt = grs_pkg::S_CLR;
          end else begin
            state_nxt = grs_pkg::S_DONE;
          end
        end
      end
      grs_pkg::S_EDGE: state_nxt = grs_pkg::S_DONE;
      grs_pkg::S_CLR: begin
        if (clr_last) begin
          state_nxt = grs_pkg::S_POP;
        end
      end
      grs_pkg::S_POP: begin
        state_nxt = fr_empty ? grs_pkg::S_DONE : grs_pkg::S_NODE;
      end
      grs_pkg::S_NODE: state_nxt = grs_pkg::S_CHK;
      grs_pkg::S_CHK: begin
        if (!grs_pkg::node_ok(cur_r, NC) || vis_q_r) begin
          state_nxt = grs_pkg::S_POP;
        end else if (cur_r == goal_r) begin
          state_nxt = grs_pkg::S_DONE;
        end else begin
          state_nxt = grs_pkg::S_DEG;
        end
      end
      grs_pkg::S_DEG: begin
        state_nxt = (deg_rdata == 9'd0) ? grs_pkg::S_POP : grs_pkg::S_NBR;
      end
      grs_pkg::S_NBR: state_nxt = grs_pkg::S_PUSH;
      grs_pkg::S_PUSH: begin
        state_nxt = (slot_inc == deg_r) ? grs_pkg::S_POP : grs_pkg::S_NBR;
      end
      grs_pkg::S_DONE: begin
        if (out_ready) begin
          state_nxt = grs_pkg::S_IDLE;
        end
      end
      default: state_nxt = grs_pkg::S_IDLE;
    endcase
  end

  // Outputs, memory requests and datapath updates
  always_comb begin
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    gs_cmd       = '0;
    fr_cmd       = '0;
    fr_push_data = in_data.from_node;
    vis_we       = 1'b0;
    vis_re       = 1'b0;
    vis_wdata    = 1'b0;
    vis_waddr    = '0;
    vis_raddr    = '0;
    cur_nxt      = cur_r;
    goal_nxt     = goal_r;
    deg_nxt      = deg_r;
    slot_nxt     = slot_r;
    count_nxt    = count_r;
    nb_nxt       = nb_r;
    out_nxt      = out_r;
    case (state_r)
      grs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          cur_nxt  = in_data.from_node;
          goal_nxt = in_data.to_node;
          if (in_data.op == grs_pkg::OP_EDGE) begin
            gs_cmd.deg_rd = 1'b1;
            gs_cmd.node   = in_data.from_node;
          end else begin
            count_nxt    = '0;
            slot_nxt     = '0;
            out_nxt      = '{status: grs_pkg::ST_UNREACH, explored_count: 9'd0};
            fr_cmd.clear = 1'b1;
            fr_cmd.push  = grs_pkg::node_ok(in_data.from_node, NC);
          end
        end
      end
      grs_pkg::S_EDGE: begin
        out_nxt = '{status: grs_pkg::ST_DROPPED, explored_count: 9'd0};
        if (grs_pkg::node_ok(cur_r, NC) && grs_pkg::node_ok(goal_r, NC) &&
            deg_rdata < MD) begin
          gs_cmd.nb_wr     = 1'b1;
          gs_cmd.deg_wr    = 1'b1;
          gs_cmd.node      = cur_r;
          gs_cmd.slot      = deg_rdata[7:0];
          gs_cmd.nb_wdata  = goal_r;
          gs_cmd.deg_wdata = deg_rdata + 9'd1;
          out_nxt.status   = grs_pkg::ST_ADDED;
        end
      end
      grs_pkg::S_CLR: begin
        // Clear one visited bit per cycle
        vis_we    = 1'b1;
        vis_waddr = slot_r[NIW-1:0];
        slot_nxt  = slot_inc;
      end
      grs_pkg::S_POP: begin
        if (fr_empty) begin
          out_nxt = '{status: grs_pkg::ST_UNREACH, explored_count: count_r};
        end else begin
          fr_cmd.pop = 1'b1;
        end
      end
      grs_pkg::S_NODE: begin
        cur_nxt   = fr_pop_data;
        vis_re    = 1'b1;
        vis_raddr = fr_pop_data[NIW-1:0];
      end
      grs_pkg::S_CHK: begin
        if (grs_pkg::node_ok(cur_r, NC) && !vis_q_r) begin
          vis_we    = 1'b1;
          vis_wdata = 1'b1;
          vis_waddr = cur_r[NIW-1:0];
          count_nxt = count_r + 9'd1;
          if (cur_r == goal_r) begin
            out_nxt = '{status: grs_pkg::ST_FOUND, explored_count: count_r + 9'd1};
          end else begin
            gs_cmd.deg_rd = 1'b1;
            gs_cmd.node   = cur_r;
          end
        end
      end
      grs_pkg::S_DEG: begin
        deg_nxt  = deg_rdata;
        slot_nxt = '0;
        if (deg_rdata != 9'd0) begin
          gs_cmd.nb_rd = 1'b1;
          gs_cmd.node  = cur_r;
          gs_cmd.slot  = 8'd0;
        end
      end
      grs_pkg::S_NBR: begin
        // Hold the neighbor while its visited bit is read
        nb_nxt    = nb_rdata;
        vis_re    = 1'b1;
        vis_raddr = nb_rdata[NIW-1:0];
      end
      grs_pkg::S_PUSH: begin
        // Push an unvisited neighbor, then fetch the next slot
        fr_push_data = nb_r;
        if (grs_pkg::node_ok(nb_r, NC) && !vis_q_r) begin
          fr_cmd.push = 1'b1;
        end
        slot_nxt = slot_inc;
        if (slot_inc != deg_r) begin
          gs_cmd.nb_rd = 1'b1;
          gs_cmd.node  = cur_r;
          gs_cmd.slot  = slot_inc[7:0];
        end
      end
      grs_pkg::S_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= grs_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    goal_r <= goal_nxt;
    deg_r  <= deg_nxt;
    slot_r <= slot_nxt;
    nb_r   <= nb_nxt;
    out_r  <= out_nxt;
  end

  // Visited map memory
  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    if (vis_re) begin
      vis_q_r <= vis_mem[vis_raddr];
    end
  end

  assign out_data = out_r;

  // One transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while result pending");

  // A found goal has been counted
  a_found_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == grs_pkg::ST_FOUND) |->
      (out_data.explored_count != 9'd0))
    else $error("found with zero count");

  // Edge results carry no count
  a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == grs_pkg::ST_ADDED ||
                   out_data.status == grs_pkg::ST_DROPPED)) |->
      (out_data.explored_count == 9'd0))
    else $error("edge result with nonzero count");

  // Count never exceeds the node range
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 9'(NU)) else $error("visited count out of range");

endmodule

// File: sim/graph_reachability_search_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for graph_reachability_search: edge loads and searches in both modes.
// Depends on grs_pkg and the graph_reachability_search RTL; reads no files.
module graph_reachability_search_test;

  // Holds a copy of the graph, predicts each answer and checks results in order
  class reach_scoreboard;
    logic [7:0] nbrs[256][16];
    logic [4:0] degree[256];
    logic mode;
    grs_pkg::out_t expected_q[$];
    int errors, n_added, n_dropped, n_found, n_unreach, n_results;

    function void clear_graph();
      foreach (degree[i]) degree[i] = '0;
      mode = grs_pkg::MODE_DFS;
    endfunction

    // Walks the graph from start to goal with a stack or a queue frontier
    function grs_pkg::out_t walk(logic [7:0] start, logic [7:0] goal);
      bit visited[256];
      logic [7:0] frontier[$];
      logic [7:0] node;
      grs_pkg::out_t r;
      r.status = grs_pkg::ST_UNREACH;
      r.explored_count = '0;
      frontier = {frontier, start};
      while (frontier.size() > 0) begin
        node = (mode == grs_pkg::MODE_BFS) ? frontier.pop_front() : frontier.pop_back();
        if (visited[node]) continue;
        visited[node] = 1'b1;
        r.explored_count++;
        if (node == goal) begin
          r.status = grs_pkg::ST_FOUND;
          return r;
        end
        for (int i = 0; i < degree[node]; i++)
          if (!visited[nbrs[node][i]]) frontier = {frontier, nbrs[node][i]};
      end
      return r;
    endfunction

    // Notes an accepted input transaction and queues its answer
    function void note_input(grs_pkg::in_t d);
      grs_pkg::out_t r;
      if (d.op == grs_pkg::OP_EDGE) begin
        r.explored_count = '0;
        if (degree[d.from_node] >= 16) r.status = grs_pkg::ST_DROPPED;
        else begin
          nbrs[d.from_node][degree[d.from_node]] = d.to_node;
          degree[d.from_node]++;
          r.status = grs_pkg::ST_ADDED;
        end
      end else begin
        r = walk(d.from_node, d.to_node);
      end
      expected_q = {expected_q, r};
    endfunction

    // Compares a result transaction with the oldest expectation
    function void check_result(grs_pkg::out_t got);
      grs_pkg::out_t exp;
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d count=%0d", $time, got.status,
                 got.explored_count);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      case (exp.status)
        grs_pkg::ST_ADDED:   n_added++;
        grs_pkg::ST_DROPPED: n_dropped++;
        grs_pkg::ST_FOUND:   n_found++;
        default:             n_unreach++;
      endcase
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, exp.status,
                 got.status);
        errors++;
      end
      if (got.explored_count !== exp.explored_count) begin
        $display("%0t: explored_count mismatch expected %0d actual %0d", $time,
                 exp.explored_count, got.explored_count);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready, cfg_search_mode;
  grs_pkg::in_t in_data;
  grs_pkg::out_t out_data;
  reach_scoreboard sb;
  bit no_gaps;
  bit hold_request;

  graph_reachability_search DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_search_mode(cfg_search_mode)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one input transaction and waits for acceptance; valid stays high
  task automatic send_item(grs_pkg::in_t d);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_input(d);
  endtask

  task automatic send_op(logic op, logic [7:0] a, logic [7:0] b);
    grs_pkg::in_t d;
    d.op = op;
    d.from_node = a;
    d.to_node = b;
    send_item(d);
  endtask

  // Drains outstanding results, then writes the mode register
  task automatic write_mode(logic m);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_search_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    sb.mode = m;
    cfg_valid <= 1'b0;
  endtask

  // Receiver side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!no_gaps && $urandom_range(0, 9) < 3) begin
        out_ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Result monitor
  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);

  // Stimulus and end of run
  initial begin
    int span;
    sb = new();
    sb.clear_graph();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_search_mode = grs_pkg::MODE_DFS;
    no_gaps = 1'b0;
    hold_request = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme nodes, start equals goal, unreachable goal, full list
    send_op(grs_pkg::OP_EDGE, 8'd0, 8'd1);
    send_op(grs_pkg::OP_EDGE, 8'd1, 8'd2);
    send_op(grs_pkg::OP_EDGE, 8'd0, 8'd3);
    send_op(grs_pkg::OP_EDGE, 8'd3, 8'd255);
    send_op(grs_pkg::OP_EDGE, 8'd255, 8'd0);
    send_op(grs_pkg::OP_EDGE, 8'd254, 8'd255);
    send_op(grs_pkg::OP_SEARCH, 8'd0, 8'd255);
    send_op(grs_pkg::OP_SEARCH, 8'd5, 8'd5);
    send_op(grs_pkg::OP_SEARCH, 8'd1, 8'd0);
    send_op(grs_pkg::OP_SEARCH, 8'd255, 8'd2);
    send_op(grs_pkg::OP_SEARCH, 8'd0, 8'd254);
    for (int i = 0; i < 17; i++) send_op(grs_pkg::OP_EDGE, 8'd9, 8'(255 - i));
    send_op(grs_pkg::OP_SEARCH, 8'd9, 8'd0);

    // Random phases alternating the mode; node ranges kept small for dense graphs
    for (int p = 0; p < 6; p++) begin
      write_mode(p[0]);
      no_gaps = (p == 3);
      if (p == 2) hold_request = 1'b1;
      span = (p < 2) ? 15 : (p < 4) ? 47 : 127;
      for (int k = 0; k < 180; k++) begin
        logic op;
        logic [7:0] a, b;
        op = ($urandom_range(0, 9) < 6) ? grs_pkg::OP_EDGE : grs_pkg::OP_SEARCH;
        if ($urandom_range(0, 4) == 0) begin
          a = 8'($urandom);
          b = 8'($urandom);
        end else begin
          a = 8'($urandom_range(0, span));
          b = 8'($urandom_range(0, span));
        end
        send_op(op, a, b);
      end
    end
    write_mode(grs_pkg::MODE_DFS);

    $display("covered %0d results: %0d edges added, %0d dropped, %0d found, %0d unreachable",
             sb.n_results, sb.n_added, sb.n_dropped, sb.n_found, sb.n_unreach);
    $display("both search modes exercised over growing graphs, with stalls on both sides");
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("graph_reachability_search regression: pass");
    else
      $display("graph_reachability_search regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #250ms;
    $display("graph_reachability_search regression: fail");
    $finish;
  end

endmodule

// File: sim.f
hdl/grs_pkg.sv
hdl/grs_graph_store.sv
hdl/grs_frontier.sv
hdl/grs_seq.sv
hdl/graph_reachability_search.sv
sim/graph_reachability_search_test.sv
